@@ sv/utf8d_pkg.sv @@
package utf8d_pkg;

	// Width of one decoded character value.
	localparam int unsigned CP_W = 21;

	// Depth of the result queue and its pointer and count widths.
	localparam int unsigned QDEPTH = 4;
	localparam int unsigned QPTR_W = $clog2(QDEPTH);
	localparam int unsigned QCNT_W = $clog2(QDEPTH + 1);

	// An input item may push up to this many results.
	localparam int unsigned MAX_PUSH = 2;

	// Fixed code points.
	localparam logic [CP_W-1:0] CP_INVALID = CP_W'(8'h3F);
	localparam logic [CP_W-1:0] CP_TERM    = '0;

	// One result item.
	typedef struct packed {
		logic [CP_W-1:0] code_point;
		logic            end_of_string;
		logic            last_of_run;
	} result_t;

	// What the decoder hands to the queue and back to the state registers.
	typedef struct packed {
		logic [1:0]      count;
		result_t         res0;
		result_t         res1;
		logic [CP_W-1:0] partial;
		logic [1:0]      pending;
	} dec_out_t;

endpackage

@@ sv/utf8d_decode.sv @@
module utf8d_decode (
	input  logic [7:0]                data_byte,
	input  logic [utf8d_pkg::CP_W-1:0] partial,
	input  logic [1:0]                pending,
	output utf8d_pkg::dec_out_t       dec
);
	import utf8d_pkg::*;

	logic            is_cont;
	logic            open_seq;
	logic            flush;
	logic            lead_has;
	result_t         lead_res;
	logic [CP_W-1:0] shifted;
	logic [1:0]      pend_dec;

	assign is_cont  = (data_byte[7:6] == 2'b10);
	assign open_seq = (pending != 2'd0);
	assign shifted  = {partial[CP_W-7:0], data_byte[5:0]};
	assign pend_dec = pending - 2'd1;
	assign flush    = open_seq && !is_cont;

	// Classify the byte as a lead byte.
	always_comb begin
		lead_has = 1'b1;
		lead_res = '{code_point: CP_TERM, end_of_string: 1'b0, last_of_run: 1'b1};
		priority if (data_byte == 8'h00) begin
			lead_res.end_of_string = 1'b1;
		end else if (data_byte[7] == 1'b0) begin
			lead_res.code_point = CP_W'(data_byte);
		end else if (data_byte[7:5] == 3'b110 || data_byte[7:4] == 4'b1110 ||
				data_byte[7:3] == 5'b11110) begin
			lead_has = 1'b0;
		end else begin
			lead_res.code_point = CP_INVALID;
		end
	end

	// Combine continuation, flush and lead handling into the step result.
	always_comb begin
		dec         = '0;
		dec.partial = partial;
		dec.pending = pending;
		if (open_seq && is_cont) begin
			dec.partial = shifted;
			dec.pending = pend_dec;
			if (pend_dec == 2'd0) begin
				dec.count = 2'd1;
				dec.res0  = '{code_point: shifted, end_of_string: 1'b0, last_of_run: 1'b1};
			end
		end else begin
			// A lead byte that opens a sequence loads the partial value.
			priority if (data_byte[7:5] == 3'b110) begin
				dec.partial = CP_W'(data_byte[4:0]);
				dec.pending = 2'd1;
			end else if (data_byte[7:4] == 4'b1110) begin
				dec.partial = CP_W'(data_byte[3:0]);
				dec.pending = 2'd2;
			end else if (data_byte[7:3] == 5'b11110) begin
				dec.partial = CP_W'(data_byte[2:0]);
				dec.pending = 2'd3;
			end else begin
				dec.pending = 2'd0;
			end
			if (flush) begin
				dec.res0 = '{code_point: partial, end_of_string: 1'b0,
					last_of_run: !lead_has};
				dec.res1  = lead_res;
				dec.count = lead_has ? 2'd2 : 2'd1;
			end else begin
				dec.res0  = lead_res;
				dec.count = lead_has ? 2'd1 : 2'd0;
			end
		end
	end

endmodule

@@ sv/utf8d_res_queue.sv @@
module utf8d_res_queue (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic [1:0]           push_count,
	input  utf8d_pkg::result_t   push0,
	input  utf8d_pkg::result_t   push1,
	output logic                 room,
	output logic                 head_valid,
	output utf8d_pkg::result_t   head,
	input  logic                 pop
);
	import utf8d_pkg::*;

	localparam logic [QCNT_W-1:0] ROOM_LIMIT = QCNT_W'(QDEPTH - MAX_PUSH);

	result_t             entry_q [QDEPTH];
	logic [QPTR_W-1:0]   wr_ptr_q;
	logic [QPTR_W-1:0]   rd_ptr_q;
	logic [QCNT_W-1:0]   count_q;
	logic [QPTR_W-1:0]   wr_next;

	assign wr_next    = wr_ptr_q + QPTR_W'(1);
	assign room       = (count_q <= ROOM_LIMIT);
	assign head_valid = (count_q != '0);
	assign head       = entry_q[rd_ptr_q];

	// Storage: up to two writes per cycle at consecutive slots.
	always_ff @(posedge clk) begin
		if (push_count != 2'd0) begin
			entry_q[wr_ptr_q] <= push0;
		end
		if (push_count == 2'd2) begin
			entry_q[wr_next] <= push1;
		end
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + QPTR_W'(push_count);
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
			end
			count_q <= count_q + QCNT_W'(push_count) - QCNT_W'(pop);
		end
	end

endmodule

@@ sv/utf8_stream_decoder_core.sv @@
// Streaming UTF-8 decoder.
// Input channel: in_valid, in_stall, data_byte. One UTF-8 byte is taken per
// item at a clock edge where in_valid is high and in_stall is low.
// Output channel: out_valid, out_stall, code_point, end_of_string,
// last_of_run. A byte yields zero, one or two result items; last_of_run
// marks the final one from a byte, end_of_string marks the terminator.
// Results are written into the queue when the byte that causes them is
// accepted and presented from there. Throughput: one byte per cycle while
// the receiver keeps up; a byte that interrupts a sequence and also yields
// a character produces two results, which leave one per cycle.
// Results wait in a four-entry queue; in_stall rises when fewer than two
// free slots remain, so a stalled receiver backs up into the sender
// and nothing is dropped. A waiting result holds steady.
// Reset clears the queue and closes any open sequence; the next byte is
// taken as a lead byte.
module utf8_stream_decoder_core (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_stall,
	input  logic [7:0]                 data_byte,
	output logic                       out_valid,
	input  logic                       out_stall,
	output logic [utf8d_pkg::CP_W-1:0] code_point,
	output logic                       end_of_string,
	output logic                       last_of_run
);
	import utf8d_pkg::*;

	logic [CP_W-1:0] partial_q;
	logic [1:0]      pending_q;
	dec_out_t        dec;
	logic            accept;
	logic            room;
	logic            head_valid;
	result_t         head;

	assign in_stall = !room;
	assign accept   = in_valid && room;

	// Per-byte decode from the current sequence state.
	utf8d_decode u_decode (
		.data_byte (data_byte),
		.partial   (partial_q),
		.pending   (pending_q),
		.dec       (dec)
	);

	// Sequence state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			partial_q <= '0;
			pending_q <= '0;
		end else if (accept) begin
			partial_q <= dec.partial;
			pending_q <= dec.pending;
		end
	end

	// Result queue decouples the two sides.
	utf8d_res_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_count (accept ? dec.count : 2'd0),
		.push0      (dec.res0),
		.push1      (dec.res1),
		.room       (room),
		.head_valid (head_valid),
		.head       (head),
		.pop        (head_valid && !out_stall)
	);

	assign out_valid     = head_valid;
	assign code_point    = head.code_point;
	assign end_of_string = head.end_of_string;
	assign last_of_run   = head.last_of_run;

endmodule

@@ sv/utf8d_checker.sv @@
module utf8d_checker (
	input logic                       clk,
	input logic                       arst_n,
	input logic                       in_valid,
	input logic                       in_stall,
	input logic [7:0]                 data_byte,
	input logic                       out_valid,
	input logic                       out_stall,
	input logic [utf8d_pkg::CP_W-1:0] code_point,
	input logic                       end_of_string,
	input logic                       last_of_run
);
	import utf8d_pkg::*;

	// A stalled result stays offered.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("result dropped while stalled");

	// An accepted ASCII byte or terminator always leaves a result offered next cycle.
	a_ascii_result: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && !data_byte[7] |=> out_valid)
		else $error("no result after an ASCII byte");

	// The terminator is zero and closes its run.
	a_term_shape: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && end_of_string |-> last_of_run && code_point == CP_TERM)
		else $error("malformed terminator");

	// A result that is not last of its run is always followed by another.
	a_run_follow: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_stall && !last_of_run |=> out_valid)
		else $error("run cut short");

endmodule

bind utf8_stream_decoder_core utf8d_checker u_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.in_valid      (in_valid),
	.in_stall      (in_stall),
	.data_byte     (data_byte),
	.out_valid     (out_valid),
	.out_stall     (out_stall),
	.code_point    (code_point),
	.end_of_string (end_of_string),
	.last_of_run   (last_of_run)
);
